@@ hdl/lbf_pkg.sv @@
// ----------------------------------------------------------------------------
// lbf_pkg
// Shared types, codes and arithmetic helpers for the LED fade sequencer.
// ----------------------------------------------------------------------------
package lbf_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned WAIT_W  = 8;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Fall behavior thresholds.
    localparam logic [CHAN_W-1:0] FALL_FLOOR = 8'd3;
    localparam logic [CHAN_W-1:0] BLACK_CUT  = 8'd5;
    localparam logic [CHAN_W-1:0] TEN        = 8'd10;

    // Effect mode codes.
    localparam logic [MODE_W-1:0] MODE_BREATHE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RISE_ONLY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FALL_ONLY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_INTVL  = 3'd5;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_RISE = 4'b0010,
        PH_FALL = 4'b0100,
        PH_LONE = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [MODE_W-1:0]  effect_mode;
        logic [COUNT_W-1:0] repeat_count;
        logic [WAIT_W-1:0]  frame_interval;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0]  cur_red;
        logic [CHAN_W-1:0]  cur_green;
        logic [CHAN_W-1:0]  cur_blue;
        t_phase             phase;
        logic [COUNT_W-1:0] cycles_left;
        logic [WAIT_W-1:0]  wait_left;
    } t_state;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_valid;
        logic              busy_res;
        logic              finished;
    } t_result;

    // Exact divide by ten for an 8-bit value: x * 205 >> 11.
    function automatic logic [CHAN_W-1:0] div10(input logic [CHAN_W-1:0] x);
        logic [18:0] prod;
        prod = {11'd0, x} * 19'd205;
        return prod[18:11];
    endfunction

    // One rise step of a channel toward its target.
    function automatic logic [CHAN_W-1:0] rise_ch(input logic [CHAN_W-1:0] c,
                                                  input logic [CHAN_W-1:0] t);
        logic [CHAN_W-1:0] span;
        span = t - c;
        if (c < t) begin
            return c + div10(span);
        end
        return t;
    endfunction

    // One fall step of a channel.
    function automatic logic [CHAN_W-1:0] fall_ch(input logic [CHAN_W-1:0] c);
        if (c > FALL_FLOOR) begin
            if (c < TEN) begin
                return c - 8'd1;
            end
            return c - div10(c);
        end
        return c;
    endfunction

endpackage

@@ hdl/lbf_if.sv @@
// ----------------------------------------------------------------------------
// lbf_if
// Handshake channels of the LED fade sequencer: tick input, frame output
// and configuration writes.
// ----------------------------------------------------------------------------
interface lbf_in_if;
    logic valid;
    logic ready;
    logic start_req;

    modport source (output valid, output start_req, input ready);
    modport sink   (input valid, input start_req, output ready);
endinterface

interface lbf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_valid;
    logic       busy_res;
    logic       finished;

    modport source (output valid, output red, output green, output blue,
                    output frame_valid, output busy_res, output finished,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_valid, input busy_res, input finished,
                    output ready);
endinterface

interface lbf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/lbf_step.sv @@
// ----------------------------------------------------------------------------
// lbf_step
// Combinational next-state and frame computation for one tick.
// ----------------------------------------------------------------------------
module lbf_step
    import lbf_pkg::*;
(
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    input  logic    i_start_req,
    output t_state  o_state,
    output t_result o_result
);

    t_state            s;
    logic              go;
    logic              fin;
    logic              cycle_end;
    logic              same;
    logic [CHAN_W-1:0] rr, rg, rb;
    logic [CHAN_W-1:0] fr, fg, fb;
    logic [COUNT_W-1:0] cyc_dec;

    always_comb begin
        s         = i_state;
        go        = 1'b0;
        fin       = 1'b0;
        cycle_end = 1'b0;
        same      = 1'b0;
        rr = '0; rg = '0; rb = '0;
        fr = '0; fg = '0; fb = '0;
        cyc_dec = '0;

        if (s.phase == PH_IDLE) begin
            if (i_start_req) begin
                s.wait_left = '0;
                case (i_cfg.effect_mode)
                    MODE_BREATHE: begin
                        if (i_cfg.repeat_count == '0) begin
                            fin = 1'b1;
                        end else begin
                            s.cycles_left = i_cfg.repeat_count;
                            s.cur_red   = '0;
                            s.cur_green = '0;
                            s.cur_blue  = '0;
                            s.phase     = PH_RISE;
                        end
                    end
                    MODE_RISE_ONLY: begin
                        s.cycles_left = COUNT_W'(1);
                        s.cur_red   = '0;
                        s.cur_green = '0;
                        s.cur_blue  = '0;
                        s.phase     = PH_LONE;
                    end
                    MODE_FALL_ONLY: begin
                        s.cur_red   = i_cfg.red;
                        s.cur_green = i_cfg.green;
                        s.cur_blue  = i_cfg.blue;
                        if ((i_cfg.red | i_cfg.green | i_cfg.blue) == '0) begin
                            fin = 1'b1;
                        end else begin
                            s.cycles_left = COUNT_W'(1);
                            s.phase       = PH_FALL;
                        end
                    end
                    default: begin
                    end
                endcase
                go = (s.phase != PH_IDLE);
            end
        end else if (s.wait_left != '0) begin
            s.wait_left = s.wait_left - WAIT_W'(1);
        end else begin
            go = 1'b1;
        end

        if (go) begin
            if (s.phase == PH_RISE || s.phase == PH_LONE) begin
                rr = rise_ch(s.cur_red, i_cfg.red);
                rg = rise_ch(s.cur_green, i_cfg.green);
                rb = rise_ch(s.cur_blue, i_cfg.blue);
                same = (rr == s.cur_red) && (rg == s.cur_green) && (rb == s.cur_blue);
                s.cur_red   = rr;
                s.cur_green = rg;
                s.cur_blue  = rb;
                if (same) begin
                    if (s.phase == PH_LONE) begin
                        s.phase = PH_IDLE;
                        fin     = 1'b1;
                    end else if ((rr | rg | rb) != '0) begin
                        s.phase = PH_FALL;
                    end else begin
                        cycle_end = 1'b1;
                    end
                end
            end else begin
                fr = fall_ch(s.cur_red);
                fg = fall_ch(s.cur_green);
                fb = fall_ch(s.cur_blue);
                // Once every channel is dim enough the frame snaps to black.
                if (fr <= BLACK_CUT && fg <= BLACK_CUT && fb <= BLACK_CUT) begin
                    fr = '0; fg = '0; fb = '0;
                end
                s.cur_red   = fr;
                s.cur_green = fg;
                s.cur_blue  = fb;
                if ((fr | fg | fb) == '0) begin
                    cycle_end = 1'b1;
                end
            end

            if (cycle_end) begin
                cyc_dec       = s.cycles_left - COUNT_W'(1);
                s.cycles_left = cyc_dec;
                if (cyc_dec == '0) begin
                    s.phase = PH_IDLE;
                    fin     = 1'b1;
                end else begin
                    s.phase = PH_RISE;
                end
            end
            s.wait_left = (s.phase == PH_IDLE) ? '0 : i_cfg.frame_interval;
        end
    end

    assign o_state              = s;
    assign o_result.red         = s.cur_red;
    assign o_result.green       = s.cur_green;
    assign o_result.blue        = s.cur_blue;
    assign o_result.frame_valid = go;
    assign o_result.busy_res    = (s.phase != PH_IDLE);
    assign o_result.finished    = fin;

endmodule

@@ hdl/led_breathe_fade_sequencer.sv @@
// ----------------------------------------------------------------------------
// led_breathe_fade_sequencer
// Steps an RGB breathe / rise / fall effect by at most one frame per tick item.
// ----------------------------------------------------------------------------
//
// Channel    Dir   Payload                                      Accepted when
// i_item     in    start_req                                    valid && ready
// o_result   out   red, green, blue, frame_valid, busy_res,     valid && ready
//                  finished
// i_cfg      in    index (3 bits), data (16 bits)               valid && ready
//
// The step logic reads the effect state registers, and the new state and the
// result item are both written at the accept edge. A new tick can be taken
// while a result is still held, if that result is taken at the same edge.
// The result register is the only stage; a tick is taken whenever it is empty
// or its item is taken in the same cycle, so o_result.ready stalls i_item.
// Synchronous active-low reset clears the color, phase and counters, and
// loads the configuration defaults (repeat count one, everything else zero).
// Configuration writes are always taken; indexes past the list are dropped.
module led_breathe_fade_sequencer
    import lbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lbf_in_if.sink     i_item,
    lbf_out_if.source  o_result,
    lbf_cfg_if.sink    i_cfg
);

    // Configuration registers. Targets are read live by every rise step; mode and
    // repeat count only matter at the start of a run.
    t_cfg    r_cfg;

    // Effect state carried from tick to tick.
    t_state  r_state;
    t_state  n_state;

    // Result stage.
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;

    logic    item_acc;
    logic    out_acc;

    assign i_cfg.ready  = 1'b1;
    assign out_acc      = r_out_valid && o_result.ready;
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign item_acc     = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red            <= '0;
            r_cfg.green          <= '0;
            r_cfg.blue           <= '0;
            r_cfg.effect_mode    <= MODE_BREATHE;
            r_cfg.repeat_count   <= COUNT_W'(1);
            r_cfg.frame_interval <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TARGET_RED:   r_cfg.red            <= i_cfg.data[CHAN_W-1:0];
                REG_TARGET_GREEN: r_cfg.green          <= i_cfg.data[CHAN_W-1:0];
                REG_TARGET_BLUE:  r_cfg.blue           <= i_cfg.data[CHAN_W-1:0];
                REG_EFFECT_MODE:  r_cfg.effect_mode    <= i_cfg.data[MODE_W-1:0];
                REG_REPEAT_COUNT: r_cfg.repeat_count   <= i_cfg.data[COUNT_W-1:0];
                REG_FRAME_INTVL:  r_cfg.frame_interval <= i_cfg.data[WAIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // All of one tick's work: start decode, the wait countdown and one
    // rise or fall step on the three channels.
    lbf_step u_step (
        .i_state     (r_state),
        .i_cfg       (r_cfg),
        .i_start_req (i_item.start_req),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cur_red     <= '0;
            r_state.cur_green   <= '0;
            r_state.cur_blue    <= '0;
            r_state.phase       <= PH_IDLE;
            r_state.cycles_left <= '0;
            r_state.wait_left   <= '0;
            r_out_valid         <= 1'b0;
        end else begin
            if (item_acc) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The payload needs no reset; it is only looked at while valid.
    always_ff @(posedge i_clk) begin
        if (item_acc) begin
            r_result <= n_result;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.red         = r_result.red;
    assign o_result.green       = r_result.green;
    assign o_result.blue        = r_result.blue;
    assign o_result.frame_valid = r_result.frame_valid;
    assign o_result.busy_res    = r_result.busy_res;
    assign o_result.finished    = r_result.finished;

`ifndef SYNTHESIS
    // A run that ends cannot still be reported as running.
    a_fin_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_result.finished && r_result.busy_res))
        else $error("finished and busy_res set in the same item");

    // A tick spent waiting between frames must not produce a frame.
    a_wait_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item_acc && r_state.phase != PH_IDLE && r_state.wait_left != '0)
        |=> !r_result.frame_valid)
        else $error("frame emitted during inter-frame wait");

    // Leaving a run always clears the wait counter.
    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_IDLE) |-> (r_state.wait_left == '0))
        else $error("wait counter left nonzero while idle");

    // The state only moves when a tick item is taken.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !item_acc |=> $stable(r_state))
        else $error("effect state changed without a tick");
`endif

endmodule
